### hw/rtl/tile_dedup_flip_match_assert.svh
// ----------------------------------------------------------------------------
// tile_dedup_flip_match assertion macros
// Concurrent checks on clk; the reset-qualified form is disabled while rst.
// ----------------------------------------------------------------------------
`ifndef TILE_DEDUP_FLIP_MATCH_ASSERT_SVH
`define TILE_DEDUP_FLIP_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define TDFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TDFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TDFM_ASSERT(lbl, prop, msg)
`define TDFM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hw/rtl/tdfm_pkg.sv
// ----------------------------------------------------------------------------
// tdfm_pkg
// Shared types, sizes and codes of the tile dedup block.
// ----------------------------------------------------------------------------
package tdfm_pkg;

  localparam int MAX_TILES = 256;
  localparam int TILE_DIM  = 8;

  localparam int PIX_W     = 2;
  localparam int ROW_BITS  = PIX_W * TILE_DIM;
  localparam int ROW_W     = $clog2(TILE_DIM);
  localparam int TILE_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W     = $clog2(MAX_TILES + 1);
  localparam int ROW_AW    = TILE_W + ROW_W;
  localparam int PAL_W     = 3;
  localparam int IDX_W     = 8;
  localparam int FUNC_W    = 2;
  localparam int FLIP_W    = 2;
  localparam int NUM_FLIPS = 4;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEDUP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // Flip codes: bit 0 horizontal, bit 1 vertical
  localparam logic [FLIP_W-1:0] FLIP_NONE = 2'd0;
  localparam logic [FLIP_W-1:0] FLIP_H    = 2'd1;
  localparam logic [FLIP_W-1:0] FLIP_V    = 2'd2;
  localparam logic [FLIP_W-1:0] FLIP_HV   = 2'd3;

  typedef logic [ROW_BITS-1:0] row_t;
  typedef row_t [TILE_DIM-1:0] tile_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  tile_index;
    logic [FLIP_W-1:0] flip_code;
    logic [PAL_W-1:0]  matched_palette;
    logic              appended;
    logic              table_full;
  } res_t;

  // Mirror a row left to right, pixel by pixel
  function automatic row_t mirror_row(input row_t r);
    row_t o;
    o = '0;
    for (int p = 0; p < TILE_DIM; p++) begin
      o[PIX_W*(TILE_DIM-1-p) +: PIX_W] = r[PIX_W*p +: PIX_W];
    end
    return o;
  endfunction

endpackage

### hw/rtl/tile_dedup_flip_match.sv
// ----------------------------------------------------------------------------
// tile_dedup_flip_match: rows taken one a cycle; input stalls during a search
// or append, and a final row is held while a result waits. Clear empties, push
// writes rows, find checks palettes, then reads, waits for and compares
// same-palette tiles; a dedup miss appends. Sync reset empties, flips off.
// ----------------------------------------------------------------------------
`include "tile_dedup_flip_match_assert.svh"

module tile_dedup_flip_match
  import tdfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [ROW_BITS-1:0] row_pixels,
  input  logic              row_last,
  input  logic [PAL_W-1:0]  tile_pal,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [IDX_W-1:0]  tile_index,
  output logic [FLIP_W-1:0] flip_code,
  output logic [PAL_W-1:0]  matched_palette,
  output logic              appended,
  output logic              table_full
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRD  = 3'd1;
  localparam logic [2:0] ST_PCHK = 3'd2;
  localparam logic [2:0] ST_ROWS = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_APP  = 3'd6;

  localparam logic [ROW_W-1:0] ROW_LAST_IDX = ROW_W'(TILE_DIM - 1);
  localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_TILES);

  logic [2:0]        state;
  logic              flips_enable;
  logic [ROW_W-1:0]  row_counter;
  logic [CNT_W-1:0]  num_tiles;
  logic [CNT_W-1:0]  search_t;
  logic [ROW_W-1:0]  row_idx;
  logic [FUNC_W-1:0] cur_func;
  logic [PAL_W-1:0]  cur_pal;
  logic              cap_en;
  logic [ROW_W-1:0]  cap_row;
  res_t              res;
  tile_t             incoming_rows;
  tile_t             tile_buf;

  logic              in_acc;
  logic              tbl_full;
  logic [NUM_FLIPS-1:0] hit;
  logic [FLIP_W-1:0] hit_flip;

  logic              row_we;
  logic [ROW_AW-1:0] row_waddr;
  row_t              row_wdata;
  logic [ROW_AW-1:0] row_raddr;
  row_t              row_rdata;
  logic              pal_we;
  logic [TILE_W-1:0] pal_waddr;
  logic [TILE_W-1:0] pal_raddr;
  logic [PAL_W-1:0]  pal_rdata;

  // Stall while busy, and hold a final row while an earlier result still waits
  assign in_stall = (state != ST_IDLE) || (out_valid && row_last);
  assign in_acc   = in_valid && !in_stall;
  assign tbl_full = (num_tiles == CNT_MAX);

  // Memory ports: search reads at search_t, append writes at num_tiles
  assign row_raddr = {search_t[TILE_W-1:0], row_idx};
  assign pal_raddr = search_t[TILE_W-1:0];
  assign row_we    = (state == ST_APP);
  assign row_waddr = {num_tiles[TILE_W-1:0], row_idx};
  assign row_wdata = incoming_rows[row_idx];
  assign pal_we    = (state == ST_APP) && (row_idx == '0);
  assign pal_waddr = num_tiles[TILE_W-1:0];

  tdfm_ram #(
    .WIDTH  (ROW_BITS),
    .DEPTH  (MAX_TILES * TILE_DIM),
    .ADDR_W (ROW_AW)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  tdfm_ram #(
    .WIDTH  (PAL_W),
    .DEPTH  (MAX_TILES),
    .ADDR_W (TILE_W)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (cur_pal),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  tdfm_match u_match (
    .stored   (tile_buf),
    .incoming (incoming_rows),
    .flips_en (flips_enable),
    .hit      (hit)
  );

  // Pick the first matching flip in order none, horizontal, vertical, both
  always_comb begin
    priority if (hit[FLIP_NONE]) begin
      hit_flip = FLIP_NONE;
    end else if (hit[FLIP_H]) begin
      hit_flip = FLIP_H;
    end else if (hit[FLIP_V]) begin
      hit_flip = FLIP_V;
    end else begin
      hit_flip = FLIP_HV;
    end
  end

  // Capture incoming rows and fetched stored rows
  always_ff @(posedge clk) begin
    if (in_acc) begin
      incoming_rows[row_counter] <= row_pixels;
    end
    cap_row <= row_idx;
    if (cap_en) begin
      tile_buf[cap_row] <= row_rdata;
    end
  end

  // Sequencer: accept rows, search, append, deliver the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      flips_enable <= 1'b0;
      row_counter  <= '0;
      num_tiles    <= '0;
      search_t     <= '0;
      row_idx      <= '0;
      cur_func     <= FUNC_PUSH;
      cur_pal      <= '0;
      cap_en       <= 1'b0;
      out_valid    <= 1'b0;
      res          <= '0;
    end else begin
      if (cfg_we) begin
        flips_enable <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      cap_en <= (state == ST_ROWS);

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            row_counter <= row_last ? '0 : row_counter + 1'b1;
            if (row_last) begin
              cur_func <= func;
              cur_pal  <= tile_pal;
              row_idx  <= '0;
              search_t <= '0;
              unique case (func)
                FUNC_CLEAR: begin
                  num_tiles <= '0;
                  res       <= '0;
                  out_valid <= 1'b1;
                end
                FUNC_PUSH: begin
                  if (tbl_full) begin
                    res <= '{found: 1'b0, tile_index: '0, flip_code: FLIP_NONE,
                             matched_palette: '0, appended: 1'b0, table_full: 1'b1};
                    out_valid <= 1'b1;
                  end else begin
                    state <= ST_APP;
                  end
                end
                default: begin
                  state <= ST_PRD;
                end
              endcase
            end
          end
        end

        // Issue a palette read, or end the search past the last tile
        ST_PRD: begin
          if (search_t == num_tiles) begin
            if (cur_func == FUNC_DEDUP && !tbl_full) begin
              row_idx <= '0;
              state   <= ST_APP;
            end else begin
              res <= '{found: 1'b0, tile_index: '0, flip_code: FLIP_NONE,
                       matched_palette: '0, appended: 1'b0,
                       table_full: (cur_func == FUNC_DEDUP)};
              out_valid <= 1'b1;
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_PCHK;
          end
        end

        // Skip tiles of another palette
        ST_PCHK: begin
          if (pal_rdata == cur_pal) begin
            row_idx <= '0;
            state   <= ST_ROWS;
          end else begin
            search_t <= search_t + 1'b1;
            state    <= ST_PRD;
          end
        end

        // Stream the stored tile's rows out of the row memory
        ST_ROWS: begin
          row_idx <= row_idx + 1'b1;
          if (row_idx == ROW_LAST_IDX) begin
            state <= ST_WAIT;
          end
        end

        ST_WAIT: begin
          state <= ST_CMP;
        end

        ST_CMP: begin
          if (|hit) begin
            res <= '{found: 1'b1, tile_index: IDX_W'(search_t), flip_code: hit_flip,
                     matched_palette: cur_pal, appended: 1'b0, table_full: 1'b0};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            search_t <= search_t + 1'b1;
            state    <= ST_PRD;
          end
        end

        // Write the incoming tile one row a cycle
        ST_APP: begin
          row_idx <= row_idx + 1'b1;
          if (row_idx == ROW_LAST_IDX) begin
            res <= '{found: 1'b0, tile_index: IDX_W'(num_tiles), flip_code: FLIP_NONE,
                     matched_palette: '0, appended: 1'b1, table_full: 1'b0};
            num_tiles <= num_tiles + 1'b1;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign found           = res.found;
  assign tile_index      = res.tile_index;
  assign flip_code       = res.flip_code;
  assign matched_palette = res.matched_palette;
  assign appended        = res.appended;
  assign table_full      = res.table_full;

  `TDFM_ASSERT(a_count_bound, num_tiles <= CNT_MAX, "tile count above table size")
  `TDFM_ASSERT(a_pchk_bound, state == ST_PCHK |-> search_t < num_tiles, "palette check past end")
  `TDFM_ASSERT(a_rows_bound, state == ST_ROWS |-> search_t < num_tiles, "row fetch past end")
  `TDFM_ASSERT(a_flags, out_valid |-> $onehot0({found, appended, table_full}), "flag clash")
  `TDFM_ASSERT(a_app_cnt, row_we && &row_idx |=> num_tiles == $past(num_tiles) + 1'b1, "count")
  `TDFM_ASSERT_ALWAYS(a_rst, rst |=> (state == ST_IDLE && !out_valid && num_tiles == '0), "reset")

endmodule

### hw/rtl/tdfm_ram.sv
// ----------------------------------------------------------------------------
// tdfm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tdfm_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tdfm_match.sv
// ----------------------------------------------------------------------------
// tdfm_match
// Compares a fetched stored tile against the incoming tile under all flips.
// ----------------------------------------------------------------------------
module tdfm_match
  import tdfm_pkg::*;
(
  input  tile_t                stored,
  input  tile_t                incoming,
  input  logic                 flips_en,
  output logic [NUM_FLIPS-1:0] hit
);

  logic [NUM_FLIPS-1:0] eq;

  // Check each flip: bit 1 reverses row order, bit 0 mirrors each row
  always_comb begin
    row_t             r;
    logic [ROW_W-1:0] src;
    eq = '1;
    for (int f = 0; f < NUM_FLIPS; f++) begin
      for (int i = 0; i < TILE_DIM; i++) begin
        src = ((f & 2) != 0) ? ROW_W'(TILE_DIM - 1 - i) : ROW_W'(i);
        r   = ((f & 1) != 0) ? mirror_row(stored[src]) : stored[src];
        if (r != incoming[i]) begin
          eq[f] = 1'b0;
        end
      end
    end
  end

  // Flipped forms count only when enabled
  assign hit = eq & {{(NUM_FLIPS-1){flips_en}}, 1'b1};

endmodule
